[rtl/sgr_pkg.sv]
package sgr_pkg;

    // Storage depth and field widths
    localparam int MAX_TAPS    = 65;
    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 18;
    localparam int FRAC_BITS   = COEFF_BITS - 2;

    // Fixed field widths of the stream items and the configuration register
    localparam int IDX_BITS = 7;
    localparam int CFG_BITS = 7;

    // Memory address, sample count and accumulator widths
    localparam int ADDR_BITS = $clog2(MAX_TAPS);
    localparam int CNT_BITS  = $clog2(MAX_TAPS + 1);
    localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_BITS  = PROD_BITS + CNT_BITS;

    // Packed stream widths, whole bytes
    localparam int S_FIELD_BITS = IDX_BITS + COEFF_BITS + SAMPLE_BITS;
    localparam int S_TDATA_BITS = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = 2;

    // Bit positions inside the input tdata word
    localparam int IDX_LSB    = 0;
    localparam int COEFF_LSB  = IDX_LSB + IDX_BITS;
    localparam int SAMPLE_LSB = COEFF_LSB + COEFF_BITS;

    // Bit positions inside the output tuser word
    localparam int USER_SAT   = 0;
    localparam int USER_SHORT = 1;

    // Request kinds carried in the input tuser bit
    localparam logic REQ_COEFF  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

endpackage

[rtl/savgol_reflect_fir_smoother_unit.sv]
// Channel    | Direction | Beat contents (lowest bit first)
// -----------+-----------+------------------------------------------------------------
// s_ (input) | in        | tdata: coeff_index, coeff_value, sample_value; tuser: req_type;
//            |           | tlast: last_sample
// m_ (output)| out       | tdata: smoothed_value; tuser: was_saturated, short_record;
//            |           | tlast: last_result
// cfg_       | in        | cfg_data: taps_in_use (window length)
//
// A coefficient beat never leaves the block busy. A sample beat that yields an output
// keeps the block busy while the single shared multiply-accumulate forms each output
// (h+1 outputs on the last sample), reading one tap per cycle from the coefficient and
// sample memories. A short record yields a single zero-valued beat marked short_record.
// Reset is synchronous and clears only control state; the memories need no clearing.
// A stalled output beat holds in the output register; new input is still taken while
// the sequencer is idle, and the sequencer waits before overwriting a held result.
module savgol_reflect_fir_smoother_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // coeff_index [6:0], coeff_value [24:7], sample_value [40:25], zero fill
    input  logic [sgr_pkg::S_TDATA_BITS-1:0]     s_tdata,
    // req_type [0]
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    // Output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // smoothed_value [15:0]
    output logic [sgr_pkg::M_TDATA_BITS-1:0]     m_tdata,
    // was_saturated [0], short_record [1]
    output logic [sgr_pkg::M_TUSER_BITS-1:0]     m_tuser,
    output logic                                 m_tlast,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sgr_pkg::CFG_BITS-1:0]         cfg_data
);
    import sgr_pkg::*;

    localparam int DW = CNT_BITS + 2;
    localparam int QW = ACC_BITS + 1 - FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t                        state_reg;
    logic [CFG_BITS-1:0]           taps_reg;
    logic [ADDR_BITS-1:0]          wp_reg;
    logic [ADDR_BITS-1:0]          calc_wp_reg;
    logic [CNT_BITS-1:0]           seen_reg;
    logic [CNT_BITS-1:0]           k_reg;
    logic [CNT_BITS-1:0]           h_reg;
    logic [CNT_BITS-1:0]           o_reg;
    logic [CNT_BITS-1:0]           j_reg;
    logic                          last_reg;
    logic                          short_reg;
    logic                          rd_v_reg;
    logic                          prod_v_reg;
    logic signed [COEFF_BITS-1:0]  coeff_rd_reg;
    logic signed [SAMPLE_BITS-1:0] sample_rd_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic                          m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]        m_data_reg;
    logic [M_TUSER_BITS-1:0]       m_tuser_reg;
    logic                          m_tlast_reg;

    logic [COEFF_BITS-1:0]         coeff_mem [MAX_TAPS];
    logic [SAMPLE_BITS-1:0]        sample_mem [MAX_TAPS];

    logic                          s_fire;
    logic                          coeff_wr;
    logic                          sample_fire;
    logic [CFG_BITS-1:0]           w_clamp;
    logic [CNT_BITS-1:0]           h_cfg;
    logic [ADDR_BITS-1:0]          wp_next;
    logic [CNT_BITS-1:0]           seen_next;
    logic                          enough;
    logic [CNT_BITS-1:0]           two_h;
    logic                          out_fire;
    logic                          more_out;
    logic                          acc_clr;
    logic [DW-1:0]                 d_raw;
    logic [DW-1:0]                 d_sel;
    logic [DW-1:0]                 pos_sum;
    logic [DW-1:0]                 pos;
    logic [ADDR_BITS-1:0]          rd_addr;
    logic signed [ACC_BITS:0]      rnd;
    logic signed [QW-1:0]          q;
    logic                          sat;
    logic [SAMPLE_BITS-1:0]        q_val;

    // Handshakes
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign sample_fire = s_fire && (s_tuser == REQ_SAMPLE);
    assign coeff_wr    = s_fire && (s_tuser == REQ_COEFF) &&
                         (s_tdata[IDX_LSB +: IDX_BITS] < IDX_BITS'(MAX_TAPS));
    assign cfg_ready   = 1'b1;

    // Window half length from the register: clamp, force odd, halve
    always_comb begin
        w_clamp = taps_reg;
        if (w_clamp > CFG_BITS'(MAX_TAPS)) begin
            w_clamp = CFG_BITS'(MAX_TAPS);
        end
        if (w_clamp < CFG_BITS'(3)) begin
            w_clamp = CFG_BITS'(3);
        end
        if (!w_clamp[0]) begin
            w_clamp = w_clamp - CFG_BITS'(1);
        end
        h_cfg = CNT_BITS'((w_clamp - CFG_BITS'(1)) >> 1);
    end

    // Ring pointer and record fill after the incoming sample
    assign wp_next   = (wp_reg == ADDR_BITS'(MAX_TAPS - 1)) ? '0 : wp_reg + ADDR_BITS'(1);
    assign seen_next = (seen_reg < CNT_BITS'(MAX_TAPS)) ? seen_reg + CNT_BITS'(1) : seen_reg;
    assign enough    = (seen_next > h_cfg);
    assign two_h     = h_reg << 1;

    // Output register handover and continuation of the end-of-record flush
    assign out_fire = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign more_out = !short_reg && last_reg && (o_reg != '0);
    assign acc_clr  = (sample_fire && enough) || (out_fire && more_out);

    // Tap distance behind the newest sample, mirrored at both record ends
    always_comb begin
        d_raw = DW'(o_reg) + DW'(h_reg) - DW'(j_reg);
        if (d_raw[DW-1]) begin
            d_sel = -d_raw;
        end else if (d_raw > DW'(k_reg)) begin
            d_sel = (DW'(k_reg) << 1) - d_raw;
        end else begin
            d_sel = d_raw;
        end
        pos_sum = DW'(calc_wp_reg) + DW'(MAX_TAPS - 1) - d_sel;
        pos     = (pos_sum >= DW'(MAX_TAPS)) ? pos_sum - DW'(MAX_TAPS) : pos_sum;
        rd_addr = pos[ADDR_BITS-1:0];
    end

    // Coefficient memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (coeff_wr) begin
            coeff_mem[s_tdata[IDX_LSB +: ADDR_BITS]] <= s_tdata[COEFF_LSB +: COEFF_BITS];
        end
        if (state_reg == ST_RUN) begin
            coeff_rd_reg <= $signed(coeff_mem[j_reg[ADDR_BITS-1:0]]);
        end
    end

    // Sample ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (sample_fire) begin
            sample_mem[wp_reg] <= s_tdata[SAMPLE_LSB +: SAMPLE_BITS];
        end
        if (state_reg == ST_RUN) begin
            sample_rd_reg <= $signed(sample_mem[rd_addr]);
        end
    end

    // Shared multiply-accumulate: product register, then accumulate
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_BITS'(sample_rd_reg) * PROD_BITS'(coeff_rd_reg);
        if (acc_clr) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_reg + ACC_BITS'(prod_reg);
        end
    end

    // Round half up, then saturate to the sample range
    always_comb begin
        rnd   = (ACC_BITS + 1)'(acc_reg) + (ACC_BITS + 1)'(1 << (FRAC_BITS - 1));
        q     = QW'(rnd >>> FRAC_BITS);
        sat   = (q[QW-1:SAMPLE_BITS-1] != '0) && (q[QW-1:SAMPLE_BITS-1] != '1);
        if (!sat) begin
            q_val = q[SAMPLE_BITS-1:0];
        end else if (q[QW-1]) begin
            q_val = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
        end else begin
            q_val = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
        end
    end

    // Sequencer, record state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            taps_reg     <= CFG_BITS'(5);
            wp_reg       <= '0;
            seen_reg     <= '0;
            rd_v_reg     <= 1'b0;
            prod_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            rd_v_reg   <= (state_reg == ST_RUN);
            prod_v_reg <= rd_v_reg;

            if (cfg_valid && cfg_ready) begin
                taps_reg <= cfg_data;
            end

            if (out_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (sample_fire) begin
                        wp_reg      <= s_tlast ? '0 : wp_next;
                        seen_reg    <= s_tlast ? '0 : seen_next;
                        calc_wp_reg <= wp_next;
                        k_reg       <= seen_next - CNT_BITS'(1);
                        h_reg       <= h_cfg;
                        o_reg       <= h_cfg;
                        j_reg       <= '0;
                        last_reg    <= s_tlast;
                        short_reg   <= !enough;
                        if (enough) begin
                            state_reg <= ST_RUN;
                        end else if (s_tlast) begin
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_RUN: begin
                    if (j_reg == two_h) begin
                        state_reg <= ST_WAIT;
                    end else begin
                        j_reg <= j_reg + CNT_BITS'(1);
                    end
                end
                ST_WAIT: begin
                    if (!rd_v_reg && !prod_v_reg) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        m_data_reg              <= short_reg ? '0 : q_val;
                        m_tuser_reg[USER_SAT]   <= !short_reg && sat;
                        m_tuser_reg[USER_SHORT] <= short_reg;
                        m_tlast_reg             <= short_reg || (last_reg && (o_reg == '0));
                        if (more_out) begin
                            o_reg     <= o_reg - CNT_BITS'(1);
                            j_reg     <= '0;
                            state_reg <= ST_RUN;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_data_reg);
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/sgr_checker.sv]
module sgr_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic                                 s_tuser,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [sgr_pkg::M_TDATA_BITS-1:0]     m_tdata,
    input  logic [sgr_pkg::M_TUSER_BITS-1:0]     m_tuser,
    input  logic                                 m_tlast
);
    import sgr_pkg::*;

    // A short-record beat closes the record and carries a zero value
    a_short_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_SHORT]) |->
            (m_tlast && !m_tuser[USER_SAT] && (m_tdata == '0)))
        else $error("short-record beat malformed");

    // A clipped output sits at one end of the sample range
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_SAT]) |->
            ((m_tdata[SAMPLE_BITS-1:0] == {1'b0, {(SAMPLE_BITS - 1){1'b1}}}) ||
             (m_tdata[SAMPLE_BITS-1:0] == {1'b1, {(SAMPLE_BITS - 1){1'b0}}})))
        else $error("saturated value not at range limit");

    // A coefficient beat never keeps the block busy
    a_coeff_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == REQ_COEFF)) |=> s_tready)
        else $error("block busy after coefficient beat");

    // A stalled output beat holds its contents
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output beat changed");

endmodule

bind savgol_reflect_fir_smoother_unit sgr_checker u_sgr_checker (.*);

[sim/tb.sv]
`timescale 1ns / 100ps

import sgr_pkg::*;

// One smoothed output beat as the block should present it.
typedef struct packed {
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
    logic                   sat;
    logic                   short_rec;
} smooth_result_t;

// Mirrors the filter state and holds the outputs still owed by the block.
class smoothing_scoreboard;
    logic [CFG_BITS-1:0]           taps_reg;
    logic signed [COEFF_BITS-1:0]  coeff_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] ring_mem [MAX_TAPS];
    int                            wr_ptr;
    int                            seen;
    int                            errors;
    smooth_result_t                expected_smooth [$];

    function new();
        taps_reg = 7'd5;
        wr_ptr   = 0;
        seen     = 0;
        errors   = 0;
    endfunction

    function void set_taps(logic [CFG_BITS-1:0] v);
        taps_reg = v;
    endfunction

    // Half window after clamping to 3..MAX_TAPS and dropping an even length by one.
    function int half_window();
        int w;
        w = int'(taps_reg);
        if (w > MAX_TAPS) w = MAX_TAPS;
        if (w < 3) w = 3;
        if (w % 2 == 0) w = w - 1;
        return (w - 1) / 2;
    endfunction

    // Output o places behind the newest sample k, mirrored at both record ends.
    function smooth_result_t filter_point(int o, int h, int k, logic fin);
        longint         acc;
        longint         rounded;
        longint         smax;
        int             d;
        int             pos;
        smooth_result_t r;
        acc  = 0;
        smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        for (int j = 0; j <= 2 * h; j++) begin
            d = o + h - j;
            if (d < 0) d = -d;
            else if (d > k) d = 2 * k - d;
            if (d < 0) d = 0;
            if (d >= MAX_TAPS) d = MAX_TAPS - 1;
            pos = (wr_ptr + 2 * MAX_TAPS - 1 - d) % MAX_TAPS;
            acc += longint'(ring_mem[pos]) * longint'(coeff_mem[j]);
        end
        // Round half up, then clip to the sample range.
        rounded = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        r.sat = 1'b0;
        if (rounded > smax) begin
            rounded = smax;
            r.sat   = 1'b1;
        end else if (rounded < -smax - 1) begin
            rounded = -smax - 1;
            r.sat   = 1'b1;
        end
        r.value     = rounded[SAMPLE_BITS-1:0];
        r.last      = fin && (o == 0);
        r.short_rec = 1'b0;
        return r;
    endfunction

    // Update the state for one accepted input beat and queue its outputs.
    function void take_beat(logic req, logic [IDX_BITS-1:0] idx,
                            logic signed [COEFF_BITS-1:0] cval,
                            logic signed [SAMPLE_BITS-1:0] sval, logic fin);
        int             h;
        int             k;
        smooth_result_t r;
        if (req == REQ_COEFF) begin
            if (idx < MAX_TAPS) coeff_mem[idx] = cval;
        end else begin
            h = half_window();
            ring_mem[wr_ptr] = sval;
            wr_ptr = (wr_ptr + 1) % MAX_TAPS;
            if (seen < MAX_TAPS) seen++;
            k = seen - 1;
            if (fin && seen < h + 1) begin
                r.value     = '0;
                r.last      = 1'b1;
                r.sat       = 1'b0;
                r.short_rec = 1'b1;
                expected_smooth.push_back(r);
            end else if (seen >= h + 1) begin
                expected_smooth.push_back(filter_point(h, h, k, fin));
                // The last sample also flushes the tail of the record.
                if (fin) begin
                    for (int o = h - 1; o >= 0; o--)
                        expected_smooth.push_back(filter_point(o, h, k, fin));
                end
            end
            if (fin) begin
                wr_ptr = 0;
                seen   = 0;
            end
        end
    endfunction

    function void compare_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // Compare one output beat with the oldest outstanding prediction.
    function void check_smoothed(logic [SAMPLE_BITS-1:0] value, logic sat,
                                 logic short_rec, logic fin);
        smooth_result_t want;
        if (expected_smooth.size() == 0) begin
            $display("%0t: unexpected output beat, expected none, actual value %0d",
                     $time, $signed(value));
            errors++;
        end else begin
            want = expected_smooth.pop_front();
            compare_field("smoothed_value", longint'($signed(want.value)),
                          longint'($signed(value)));
            compare_field("last_result", longint'(want.last), longint'(fin));
            compare_field("was_saturated", longint'(want.sat), longint'(sat));
            compare_field("short_record", longint'(want.short_rec), longint'(short_rec));
        end
    endfunction
endclass

module tb;

    localparam int CLK_HALF     = 2;
    localparam int DRAIN_CYCLES = 160;
    localparam int RANDOM_ITEMS = 340;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata   = '0;
    logic                    s_tuser   = 1'b0;
    logic                    s_tlast   = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic [M_TUSER_BITS-1:0] m_tuser;
    logic                    m_tlast;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_BITS-1:0]     cfg_data  = '0;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int counted_items = 0;

    smoothing_scoreboard sb = new();

    savgol_reflect_fir_smoother_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Output side: check every accepted beat and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_smoothed(m_tdata[SAMPLE_BITS-1:0], m_tuser[USER_SAT],
                              m_tuser[USER_SHORT], m_tlast);
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Present one input beat after a random gap and wait for its acceptance.
    task automatic send_beat(input logic req, input logic [IDX_BITS-1:0] idx,
                             input logic signed [COEFF_BITS-1:0] cval,
                             input logic signed [SAMPLE_BITS-1:0] sval, input logic fin);
        int                      gap;
        logic [S_TDATA_BITS-1:0] word;
        gap = 0;
        while (gap < 16 && $urandom_range(0, 99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[IDX_LSB +: IDX_BITS]       = idx;
        word[COEFF_LSB +: COEFF_BITS]   = cval;
        word[SAMPLE_LSB +: SAMPLE_BITS] = sval;
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= req;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sb.take_beat(req, idx, cval, sval, fin);
        if (req == REQ_SAMPLE || idx < MAX_TAPS) counted_items++;
    endtask

    // Stop sending, let every owed output arrive, then allow the pipeline to settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_smooth.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_taps(input logic [CFG_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_taps(v);
    endtask

    // A coefficient write with random index, so some land outside the store.
    task automatic stray_coeff();
        send_beat(REQ_COEFF, IDX_BITS'($urandom_range(0, 127)), COEFF_BITS'($urandom),
                  SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // One record of samples; style picks full-range, slowly varying or extreme values.
    task automatic run_record(input int len, input logic close, input int style);
        int                            level;
        logic signed [SAMPLE_BITS-1:0] sval;
        level = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 5) stray_coeff();
            case (style)
                0: begin
                    sval = SAMPLE_BITS'($urandom);
                end
                1: begin
                    level = level + $urandom_range(0, 400) - 200;
                    if (level > 32767) level = 32767;
                    if (level < -32768) level = -32768;
                    sval = SAMPLE_BITS'(level);
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: sval = 16'sh7FFF;
                        1: sval = 16'sh8000;
                        2: sval = 16'sh0000;
                        3: sval = -16'sd1;
                        default: sval = 16'sd1;
                    endcase
                end
            endcase
            send_beat(REQ_SAMPLE, IDX_BITS'($urandom_range(0, 127)), COEFF_BITS'($urandom),
                      sval, close && (i == len - 1));
        end
    endtask

    // Fresh taps for the active window: a plausible smoothing kernel or raw noise.
    task automatic load_kernel(input int w, input int mode);
        int base;
        base = 65536 / w;
        for (int t = 0; t < w; t++) begin
            if (mode == 0)
                send_beat(REQ_COEFF, IDX_BITS'(t),
                          COEFF_BITS'($urandom_range(0, 2 * base) - base / 4),
                          SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
            else
                send_beat(REQ_COEFF, IDX_BITS'(t), COEFF_BITS'($urandom),
                          SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    // Run-time limit.
    initial begin
        #25_000_000;
        $display("FAIL savgol_reflect_fir_smoother_unit");
        $finish;
    end

    initial begin
        int                  random_start;
        int                  h;
        int                  w;
        int                  nrec;
        int                  len;
        int                  pick;
        logic [CFG_BITS-1:0] taps;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole coefficient store: a five-point quadratic kernel, small noise beyond.
        for (int t = 0; t < MAX_TAPS; t++) begin
            case (t)
                0, 4:    send_beat(REQ_COEFF, IDX_BITS'(t), -18'sd5617,
                                   SAMPLE_BITS'($urandom), 1'b0);
                1, 3:    send_beat(REQ_COEFF, IDX_BITS'(t), 18'sd22469,
                                   SAMPLE_BITS'($urandom), 1'b0);
                2:       send_beat(REQ_COEFF, IDX_BITS'(t), 18'sd31831,
                                   SAMPLE_BITS'($urandom), 1'b0);
                default: send_beat(REQ_COEFF, IDX_BITS'(t),
                                   COEFF_BITS'($urandom_range(0, 8191) - 4096),
                                   SAMPLE_BITS'($urandom), 1'($urandom_range(0, 1)));
            endcase
        end

        // Writes beyond the store are dropped.
        send_beat(REQ_COEFF, 7'd127, 18'sh1FFFF, 16'shFFFF, 1'b1);
        send_beat(REQ_COEFF, 7'd65, -18'sd131072, 16'sh0000, 1'b0);

        // Records too short for the default window of five.
        send_beat(REQ_SAMPLE, 7'd127, 18'sh3FFFF, 16'sh7FFF, 1'b1);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, -16'sd32768, 1'b0);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, 16'sh7FFF, 1'b1);

        // Exactly half a window plus one: every output reaches across a record-end mirror.
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, 16'sh7FFF, 1'b0);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, -16'sd32768, 1'b0);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, 16'sh0000, 1'b1);

        // Window widened in the middle of a record.
        send_beat(REQ_SAMPLE, 7'd5, 18'sh1234, 16'sd100, 1'b0);
        send_beat(REQ_SAMPLE, 7'd5, 18'sh1234, 16'sd200, 1'b0);
        send_beat(REQ_SAMPLE, 7'd5, 18'sh1234, 16'sd300, 1'b0);
        wait_drained();
        write_taps(7'd9);
        for (int i = 0; i < 6; i++)
            send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, SAMPLE_BITS'(400 + 150 * i), i == 5);

        // Smallest window with extreme coefficients drives the output into both limits.
        wait_drained();
        write_taps(7'd3);
        send_beat(REQ_COEFF, 7'd0, -18'sd131072, 16'sh0000, 1'b0);
        send_beat(REQ_COEFF, 7'd1, 18'sd131071, 16'sh0000, 1'b0);
        send_beat(REQ_COEFF, 7'd2, 18'sd131071, 16'sh0000, 1'b0);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, 16'sh7FFF, 1'b0);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, 16'sh7FFF, 1'b0);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, -16'sd32768, 1'b0);
        send_beat(REQ_SAMPLE, 7'd0, 18'sh00000, -16'sd32768, 1'b1);
        wait_drained();

        // Random part: window setting, optional new kernel, then a few records.
        random_start = counted_items;
        while (counted_items < random_start + RANDOM_ITEMS) begin
            if (counted_items < random_start + RANDOM_ITEMS / 3) begin
                tx_idle_pct = 23;
                rx_idle_pct = 50;
            end else if (counted_items < random_start + 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 50;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_drained();

            // Mostly small windows; the extremes and odd register values now and then.
            if ($urandom_range(0, 99) < 60) begin
                taps = CFG_BITS'($urandom_range(3, 15));
            end else begin
                case ($urandom_range(0, 9))
                    0: taps = 7'd0;
                    1: taps = 7'd1;
                    2: taps = 7'd2;
                    3: taps = 7'd3;
                    4: taps = 7'd4;
                    5: taps = 7'd64;
                    6: taps = 7'd65;
                    7: taps = 7'd66;
                    8: taps = 7'd127;
                    default: taps = CFG_BITS'($urandom_range(0, 127));
                endcase
            end
            write_taps(taps);
            h = sb.half_window();
            w = 2 * h + 1;

            pick = $urandom_range(0, 3);
            if (pick < 2) load_kernel(w, 0);
            else if (pick == 2) load_kernel(w, 1);

            nrec = $urandom_range(1, 3);
            for (int r = 0; r < nrec; r++) begin
                pick = $urandom_range(0, 99);
                if (pick < 12) len = $urandom_range(1, h);
                else if (pick < 20) len = $urandom_range(MAX_TAPS, MAX_TAPS + 40);
                else len = $urandom_range(h + 1, 2 * h + 12);
                // An open record carries over into the next window setting.
                run_record(len, !(r == nrec - 1 && $urandom_range(0, 99) < 15),
                           $urandom_range(0, 2));
            end
        end

        wait_drained();
        if (sb.errors == 0) begin
            $display("PASS savgol_reflect_fir_smoother_unit");
        end else begin
            $display("FAIL savgol_reflect_fir_smoother_unit");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/sgr_pkg.sv
rtl/savgol_reflect_fir_smoother_unit.sv
rtl/sgr_checker.sv
sim/tb.sv
